// ===== sv/vlbi_frame_header_check_core_defines.svh =====
// Assertion helpers for the frame header checker.
// Both sample on clk and are held off while arst_n is low.
`ifndef VLBI_FRAME_HEADER_CHECK_CORE_DEFINES_SVH
`define VLBI_FRAME_HEADER_CHECK_CORE_DEFINES_SVH

`define VFHC_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vfhc: same-cycle check failed");

`define VFHC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vfhc: next-cycle check failed");

`endif

// ===== sv/vfhc_pkg.sv =====
`timescale 1ns / 1ps

package vfhc_pkg;

	localparam logic [31:0] RESET_SYNC = 32'hABADDEED;
	localparam logic [15:0] FRAME_MASK = 16'hEFFF;
	localparam logic [3:0]  BCD_MAX    = 4'd9;

	typedef struct packed {
		logic adv_s1;
		logic adv_s2;
		logic adv_s3;
	} vfhc_adv_t;

	function automatic logic digit_bad(input logic [3:0] d);
		return d > BCD_MAX;
	endfunction

	function automatic logic [7:0] bcd_pair(input logic [3:0] hi, input logic [3:0] lo);
		return ({4'd0, hi} * 8'd10) + {4'd0, lo};
	endfunction

endpackage

// ===== sv/vlbi_frame_header_check_core.sv =====
// A three-stage pipeline with per-stage valids: a request goes through s1, s2 and s3,
// whose registers drive the outputs; one request per cycle while out_ready is high.
// A stage takes a new request whenever it is empty or its successor moves on.
// Reset clears the stage valid bits and loads the sync register with 0xABADDEED.
`timescale 1ns / 1ps
`include "vlbi_frame_header_check_core_defines.svh"

module vlbi_frame_header_check_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] header_word0,
	input  logic [31:0] header_word1,
	input  logic [31:0] header_word2,
	input  logic [31:0] header_word3,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        header_ok,
	output logic        sync_error,
	output logic        bcd_error,
	output logic [15:0] frame_in_second,
	output logic [9:0]  day_of_year,
	output logic [16:0] second_of_day,
	output logic [13:0] second_fraction
);

	logic [31:0] expected_sync_q;

	logic v_s1;
	logic v_s2;
	logic v_s3;
	logic rdy_s1;
	logic rdy_s2;
	logic rdy_s3;

	vfhc_pkg::vfhc_adv_t adv;

	logic        sync_err_s1;
	logic [15:0] frame_s1;
	logic        sync_err_s2;
	logic [15:0] frame_s2;
	logic        sync_err_s3;
	logic [15:0] frame_s3;
	logic        bad_s3;

	always_comb begin
		rdy_s3 = !v_s3 || out_ready;
		rdy_s2 = !v_s2 || rdy_s3;
		rdy_s1 = !v_s1 || rdy_s2;
		adv.adv_s1 = in_valid && rdy_s1;
		adv.adv_s2 = v_s1 && rdy_s2;
		adv.adv_s3 = v_s2 && rdy_s3;
	end

	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_sync_q <= vfhc_pkg::RESET_SYNC;
		end else if (cfg_we) begin
			expected_sync_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= in_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv.adv_s1) begin
			sync_err_s1 <= header_word0 != expected_sync_q;
			frame_s1    <= header_word1[15:0] & vfhc_pkg::FRAME_MASK;
		end
		if (adv.adv_s2) begin
			sync_err_s2 <= sync_err_s1;
			frame_s2    <= frame_s1;
		end
		if (adv.adv_s3) begin
			sync_err_s3 <= sync_err_s2;
			frame_s3    <= frame_s2;
		end
	end

	vfhc_time_dec u_time_dec (
		.clk          (clk),
		.adv          (adv),
		.header_word2 (header_word2),
		.header_word3 (header_word3),
		.bad_s3       (bad_s3),
		.day_s3       (day_of_year),
		.sec_s3       (second_of_day),
		.frac_s3      (second_fraction)
	);

	assign out_valid       = v_s3;
	assign sync_error      = sync_err_s3;
	assign bcd_error       = bad_s3;
	assign header_ok       = !sync_err_s3 && !bad_s3;
	assign frame_in_second = frame_s3;

	`VFHC_ASSERT_SAME(a_zero_on_bad, out_valid && bcd_error, day_of_year == '0 && second_of_day == '0 && second_fraction == '0)
	`VFHC_ASSERT_SAME(a_time_range, out_valid && !bcd_error, day_of_year <= 10'd999 && second_of_day <= 17'd99999 && second_fraction <= 14'd9999)
	`VFHC_ASSERT_NEXT(a_accept_fills_s1, in_valid && in_ready, v_s1)
	`VFHC_ASSERT_NEXT(a_s1_holds, v_s1 && !rdy_s2, v_s1 && $stable(frame_s1) && $stable(sync_err_s1))
	`VFHC_ASSERT_SAME(a_frame_bit12, out_valid, !frame_in_second[12])

endmodule

// ===== sv/vfhc_time_dec.sv =====
`timescale 1ns / 1ps

module vfhc_time_dec (
	input  logic                 clk,
	input  vfhc_pkg::vfhc_adv_t  adv,
	input  logic [31:0]          header_word2,
	input  logic [31:0]          header_word3,
	output logic                 bad_s3,
	output logic [9:0]           day_s3,
	output logic [16:0]          sec_s3,
	output logic [13:0]          frac_s3
);

	logic        bad_s1;
	logic [3:0]  day_hi_s1;
	logic [7:0]  day_lo_s1;
	logic [3:0]  sec_hi_s1;
	logic [7:0]  sec_mid_s1;
	logic [7:0]  sec_lo_s1;
	logic [7:0]  frac_hi_s1;
	logic [7:0]  frac_lo_s1;

	logic        bad_s2;
	logic [9:0]  day_s2;
	logic [16:0] sec_s2;
	logic [13:0] frac_s2;

	logic        bad_in;
	logic [10:0] day_sum;
	logic [17:0] sec_sum;
	logic [14:0] frac_sum;

	always_comb begin
		bad_in = 1'b0;
		for (int i = 0; i < 8; i++) begin
			bad_in = bad_in | vfhc_pkg::digit_bad(header_word2[4*i +: 4]);
		end
		for (int i = 4; i < 8; i++) begin
			bad_in = bad_in | vfhc_pkg::digit_bad(header_word3[4*i +: 4]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv.adv_s1) begin
			bad_s1     <= bad_in;
			day_hi_s1  <= header_word2[31:28];
			day_lo_s1  <= vfhc_pkg::bcd_pair(header_word2[27:24], header_word2[23:20]);
			sec_hi_s1  <= header_word2[19:16];
			sec_mid_s1 <= vfhc_pkg::bcd_pair(header_word2[15:12], header_word2[11:8]);
			sec_lo_s1  <= vfhc_pkg::bcd_pair(header_word2[7:4], header_word2[3:0]);
			frac_hi_s1 <= vfhc_pkg::bcd_pair(header_word3[31:28], header_word3[27:24]);
			frac_lo_s1 <= vfhc_pkg::bcd_pair(header_word3[23:20], header_word3[19:16]);
		end
	end

	always_comb begin
		day_sum  = ({7'd0, day_hi_s1} * 11'd100) + {3'd0, day_lo_s1};
		sec_sum  = ({14'd0, sec_hi_s1} * 18'd10000) + ({10'd0, sec_mid_s1} * 18'd100)
			+ {10'd0, sec_lo_s1};
		frac_sum = ({7'd0, frac_hi_s1} * 15'd100) + {7'd0, frac_lo_s1};
	end

	always_ff @(posedge clk) begin
		if (adv.adv_s2) begin
			bad_s2  <= bad_s1;
			day_s2  <= day_sum[9:0];
			sec_s2  <= sec_sum[16:0];
			frac_s2 <= frac_sum[13:0];
		end
	end

	// A bad digit makes the decoded time meaningless, so it is forced to zero.
	always_ff @(posedge clk) begin
		if (adv.adv_s3) begin
			bad_s3  <= bad_s2;
			day_s3  <= bad_s2 ? '0 : day_s2;
			sec_s3  <= bad_s2 ? '0 : sec_s2;
			frac_s3 <= bad_s2 ? '0 : frac_s2;
		end
	end

endmodule
